// ===== rtl/mexp_pkg.sv =====
// Shared types for the modular exponentiation block: microcode word, control
// and status bundles, sequencer states and the microprogram ROM.
// No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int PC_W = 3;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_NEG,
        OP_JZ,
        OP_LOOP,
        OP_DONE
    } t_op;

    typedef enum logic {
        A_ACC,
        A_SQ
    } t_asel;

    typedef enum logic {
        B_MAG,
        B_SQ
    } t_bsel;

    typedef enum logic {
        D_ACC,
        D_SQ
    } t_dst;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_WAIT
    } t_seq_state;

    typedef struct packed {
        t_op              op;
        t_asel            a_sel;
        t_bsel            b_sel;
        t_dst             dst;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic   mul_go;
        t_asel  a_sel;
        t_bsel  b_sel;
        logic   wr_en;
        t_dst   dst;
        logic   neg_fix;
        logic   e_shift;
        logic   done;
    } t_ctrl;

    typedef struct packed {
        logic   mul_done;
        logic   ebit;
    } t_stat;

    // Microprogram step addresses
    localparam logic [PC_W-1:0] PC_REDUCE = 3'd0;
    localparam logic [PC_W-1:0] PC_NEG    = 3'd1;
    localparam logic [PC_W-1:0] PC_SCAN   = 3'd2;
    localparam logic [PC_W-1:0] PC_MULACC = 3'd3;
    localparam logic [PC_W-1:0] PC_SQUARE = 3'd4;
    localparam logic [PC_W-1:0] PC_LOOP   = 3'd5;
    localparam logic [PC_W-1:0] PC_DONE   = 3'd6;

    function automatic t_uword rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_DONE, a_sel: A_ACC, b_sel: B_SQ, dst: D_ACC, target: PC_DONE};
        unique case (pc)
            // base magnitude mod m: 1 times mag through the multiplier
            PC_REDUCE: w = '{op: OP_MUL,  a_sel: A_ACC, b_sel: B_MAG, dst: D_SQ,
                             target: PC_NEG};
            PC_NEG:    w = '{op: OP_NEG,  a_sel: A_ACC, b_sel: B_SQ,  dst: D_SQ,
                             target: PC_SCAN};
            // skip the multiply when the exponent bit is clear
            PC_SCAN:   w = '{op: OP_JZ,   a_sel: A_ACC, b_sel: B_SQ,  dst: D_ACC,
                             target: PC_SQUARE};
            PC_MULACC: w = '{op: OP_MUL,  a_sel: A_ACC, b_sel: B_SQ,  dst: D_ACC,
                             target: PC_SQUARE};
            PC_SQUARE: w = '{op: OP_MUL,  a_sel: A_SQ,  b_sel: B_SQ,  dst: D_SQ,
                             target: PC_LOOP};
            PC_LOOP:   w = '{op: OP_LOOP, a_sel: A_ACC, b_sel: B_SQ,  dst: D_ACC,
                             target: PC_SCAN};
            default:   w = '{op: OP_DONE, a_sel: A_ACC, b_sel: B_SQ,  dst: D_ACC,
                             target: PC_DONE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle,
// most significant first. Uses mexp_pkg-free plain ports.
`timescale 1ns / 1ps

module mexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [WIDTH-2:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-2:0] i_modulus,
    output logic             o_done,
    output logic [WIDTH-2:0] o_result
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-2:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-2:0] r_r;

    logic [WIDTH-1:0] m_ext;
    logic [WIDTH-1:0] dbl;
    logic [WIDTH-1:0] red1;
    logic [WIDTH-1:0] sum;
    logic [WIDTH-1:0] red2;

    always_comb begin
        m_ext = {1'b0, i_modulus};
        dbl   = {r_r, 1'b0};
        red1  = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum   = red1 + (r_b[WIDTH-1] ? {1'b0, r_a} : '0);
        red2  = (sum >= m_ext) ? sum - m_ext : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= red2[WIDTH-2:0];
            r_b <= {r_b[WIDTH-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

// ===== rtl/mexp_seq.sv =====
// Microcoded sequencer: program counter over the ROM in mexp_pkg, loop
// counter over the exponent bits, conditional jumps. Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_seq #(
    parameter int WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  mexp_pkg::t_stat i_stat,
    output mexp_pkg::t_ctrl o_ctrl,
    output logic            o_busy
);

    localparam int ITW = $clog2(WIDTH - 1);

    mexp_pkg::t_seq_state        r_state;
    mexp_pkg::t_seq_state        n_state;
    logic [mexp_pkg::PC_W-1:0]   r_pc;
    logic [mexp_pkg::PC_W-1:0]   n_pc;
    logic [ITW-1:0]              r_iter;
    logic [ITW-1:0]              n_iter;
    mexp_pkg::t_uword            uw;
    logic                        last_iter;

    assign uw        = mexp_pkg::rom(r_pc);
    assign last_iter = (r_iter == ITW'(WIDTH - 2));

    // next state, program counter and loop count
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_iter  = r_iter;
        unique case (r_state)
            mexp_pkg::SQ_IDLE: begin
                if (i_go) begin
                    n_state = mexp_pkg::SQ_RUN;
                    n_pc    = mexp_pkg::PC_REDUCE;
                    n_iter  = '0;
                end
            end
            mexp_pkg::SQ_RUN: begin
                unique case (uw.op)
                    mexp_pkg::OP_MUL:  n_state = mexp_pkg::SQ_WAIT;
                    mexp_pkg::OP_NEG:  n_pc = r_pc + 1'b1;
                    mexp_pkg::OP_JZ:   n_pc = i_stat.ebit ? r_pc + 1'b1 : uw.target;
                    mexp_pkg::OP_LOOP: begin
                        if (last_iter) begin
                            n_pc = r_pc + 1'b1;
                        end else begin
                            n_pc   = uw.target;
                            n_iter = r_iter + 1'b1;
                        end
                    end
                    mexp_pkg::OP_DONE: n_state = mexp_pkg::SQ_IDLE;
                    default:           n_state = mexp_pkg::SQ_IDLE;
                endcase
            end
            mexp_pkg::SQ_WAIT: begin
                if (i_stat.mul_done) begin
                    n_state = mexp_pkg::SQ_RUN;
                    n_pc    = r_pc + 1'b1;
                end
            end
            default: n_state = mexp_pkg::SQ_IDLE;
        endcase
    end

    // control word to the datapath
    always_comb begin
        o_ctrl.mul_go  = (r_state == mexp_pkg::SQ_RUN) && (uw.op == mexp_pkg::OP_MUL);
        o_ctrl.a_sel   = uw.a_sel;
        o_ctrl.b_sel   = uw.b_sel;
        o_ctrl.dst     = uw.dst;
        o_ctrl.wr_en   = (r_state == mexp_pkg::SQ_WAIT) && i_stat.mul_done;
        o_ctrl.neg_fix = (r_state == mexp_pkg::SQ_RUN) && (uw.op == mexp_pkg::OP_NEG);
        o_ctrl.e_shift = (r_state == mexp_pkg::SQ_RUN) && (uw.op == mexp_pkg::OP_LOOP);
        o_ctrl.done    = (r_state == mexp_pkg::SQ_RUN) && (uw.op == mexp_pkg::OP_DONE);
        o_busy         = (r_state != mexp_pkg::SQ_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mexp_pkg::SQ_IDLE;
            r_pc    <= mexp_pkg::PC_REDUCE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_iter  <= n_iter;
        end
    end

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: operand registers and
// datapath, driven by mexp_seq and using mexp_mulmod. Depends on mexp_pkg.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+----------------------
//  command   | i_base, i_exponent, i_modulus           | start high, busy low
//  result    | o_power_mod                             | o_strobe, one cycle
//
// The time from accept to the strobe is set by the bit-serial multiplier and
// grows with the count of one bits in the exponent, since each one bit adds
// a product to the squaring done for every exponent bit.
// Reset is synchronous and active low; it returns the sequencer to idle.
// The result strobe is high for one cycle and cannot be stalled; a new
// command may be taken in that same cycle.
`timescale 1ns / 1ps

module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [WIDTH-1:0] i_base,
    input  logic        [WIDTH-2:0] i_exponent,
    input  logic        [WIDTH-2:0] i_modulus,
    output logic                    o_strobe,
    output logic        [WIDTH-2:0] o_power_mod
);

    logic [WIDTH-2:0] r_m;
    logic [WIDTH-2:0] r_e;
    logic [WIDTH-2:0] r_acc;
    logic [WIDTH-2:0] r_sq;
    logic [WIDTH-1:0] r_mag;
    logic             r_neg;
    logic [WIDTH-2:0] r_res;
    logic             r_strobe;

    mexp_pkg::t_ctrl  ctrl;
    mexp_pkg::t_stat  stat;
    logic             accept;
    logic [WIDTH-2:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic             mul_done;
    logic [WIDTH-2:0] mul_res;
    logic [WIDTH-1:0] base_mag;

    assign accept   = start && !busy;
    assign base_mag = i_base[WIDTH-1] ? (~i_base + 1'b1) : i_base;

    always_comb begin
        mul_a = (ctrl.a_sel == mexp_pkg::A_SQ) ? r_sq : r_acc;
        mul_b = (ctrl.b_sel == mexp_pkg::B_MAG) ? r_mag : {1'b0, r_sq};
        stat.mul_done = mul_done;
        stat.ebit     = r_e[0];
    end

    mexp_seq #(
        .WIDTH (WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (ctrl.mul_go),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .i_modulus (r_m),
        .o_done    (mul_done),
        .o_result  (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m   <= i_modulus;
            r_e   <= i_exponent;
            r_mag <= base_mag;
            r_neg <= i_base[WIDTH-1];
            // 1 mod m: zero when the modulus is one (or zero)
            r_acc <= (i_modulus > (WIDTH-1)'(1)) ? (WIDTH-1)'(1) : '0;
        end else begin
            if (ctrl.wr_en && ctrl.dst == mexp_pkg::D_ACC) begin
                r_acc <= mul_res;
            end
            if (ctrl.wr_en && ctrl.dst == mexp_pkg::D_SQ) begin
                r_sq <= mul_res;
            end else if (ctrl.neg_fix && r_neg && r_sq != '0) begin
                r_sq <= r_m - r_sq;
            end
            if (ctrl.e_shift) begin
                r_e <= {1'b0, r_e[WIDTH-2:1]};
            end
        end
        if (ctrl.done) begin
            r_res <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ctrl.done;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_power_mod = r_res;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted command did not raise busy");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_m != '0) |-> (o_power_mod < r_m))
        else $error("result not reduced below modulus");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_go_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.mul_go |=> !mul_done)
        else $error("multiplier finished right after being started");
`endif

endmodule
